// ----- hdl/vlcbp_pkg.sv -----
// Package of the variable-length code bit packer.
// Holds field widths, operation codes and default sizes; depends on nothing.
package vlcbp_pkg;

    localparam int OP_W = 1;
    localparam int CODE_W = 32;
    localparam int LEN_W = 6;
    localparam int BYTE_W = 8;

    localparam logic [OP_W-1:0] OP_APPEND = 1'b0;
    localparam logic [OP_W-1:0] OP_FLUSH = 1'b1;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

endpackage

// ----- hdl/vlcbp_if.sv -----
// Valid/ready channel interfaces of the bit packer: code input and byte output.
// Depends on vlcbp_pkg for the field widths.
interface vlcbp_in_if;
    logic                          valid;
    logic                          ready;
    logic [vlcbp_pkg::OP_W-1:0]    operation;
    logic [vlcbp_pkg::CODE_W-1:0]  code_bits;
    logic [vlcbp_pkg::LEN_W-1:0]   code_length;

    modport source (output valid, output operation, output code_bits, output code_length,
                    input ready);
    modport sink (input valid, input operation, input code_bits, input code_length,
                  output ready);
endinterface

interface vlcbp_out_if;
    logic                          valid;
    logic                          ready;
    logic [vlcbp_pkg::BYTE_W-1:0]  out_byte;
    logic                          last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ----- hdl/vlcbp_front.sv -----
// Front end of the bit packer: accepts requests, merges codes with the pending bits and hands
// left-aligned complete bytes, or on a flush one padded byte, to the queue. Depends on vlcbp_pkg, vlcbp_if.
module vlcbp_front #(
    parameter int MAX_CODE_LEN = vlcbp_pkg::MAX_CODE_LEN_DEF,
    localparam int BUF_W = MAX_CODE_LEN + 7,
    localparam int MAX_BYTES = BUF_W / 8,
    localparam int DW = MAX_BYTES * 8,
    localparam int CNT_W = $clog2(MAX_BYTES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vlcbp_in_if.sink         i_in,
    input  logic             i_q_full,
    output logic             o_q_push,
    output logic [DW-1:0]    o_q_data,
    output logic [CNT_W-1:0] o_q_nbytes
);

    localparam int TOT_W = $clog2(BUF_W + 1);
    localparam int LW = vlcbp_pkg::LEN_W;

    logic [2:0]                   r_fill, n_fill;
    logic [6:0]                   r_pend, n_pend;
    logic                         acc;
    logic                         is_flush;
    logic [LW-1:0]                len_sat;
    logic [BUF_W+vlcbp_pkg::CODE_W-1:0] code_ext;
    logic [BUF_W-1:0]             mask;
    logic [BUF_W-1:0]             merged;
    logic [BUF_W-1:0]             aligned;
    logic [TOT_W-1:0]             total;
    logic [CNT_W-1:0]             nbytes;
    logic [7:0]                   flush_byte;

    assign i_in.ready = !i_q_full;
    assign acc = i_in.valid && i_in.ready;
    assign is_flush = (i_in.operation == vlcbp_pkg::OP_FLUSH);

    always_comb begin
        len_sat = (i_in.code_length > LW'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN)
                                                          : i_in.code_length;
        code_ext = {{BUF_W{1'b0}}, i_in.code_bits};
        mask = (BUF_W'(1) << len_sat) - BUF_W'(1);
        merged = (BUF_W'(r_pend) << len_sat) | (code_ext[BUF_W-1:0] & mask);
        total = TOT_W'(r_fill) + TOT_W'(len_sat);
        nbytes = CNT_W'(total >> 3);
        aligned = merged << (TOT_W'(BUF_W) - total);
        flush_byte = {1'b0, r_pend} << (4'd8 - {1'b0, r_fill});
        if (is_flush) begin
            o_q_data = DW'(flush_byte) << (DW - 8);
            o_q_nbytes = CNT_W'(1);
            n_fill = 3'd0;
            n_pend = 7'd0;
        end else begin
            o_q_data = aligned[BUF_W-1 -: DW];
            o_q_nbytes = nbytes;
            n_fill = total[2:0];
            n_pend = merged[6:0] & ((7'd1 << total[2:0]) - 7'd1);
        end
        o_q_push = acc && (is_flush || (nbytes != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 3'd0;
            r_pend <= 7'd0;
        end else if (acc) begin
            r_fill <= n_fill;
            r_pend <= n_pend;
        end
    end

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && is_flush) |=> (r_fill == 3'd0 && r_pend == 7'd0))
        else $error("pending bits survive a flush");

    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend >> r_fill) == 7'd0)
        else $error("pending bits above the fill level");

endmodule

// ----- hdl/vlcbp_queue.sv -----
// Short register queue that decouples the front end from the byte serializer.
// Depends on nothing beyond its parameters.
module vlcbp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

// ----- hdl/vlcbp_back.sv -----
// Back end of the bit packer: takes queued byte groups and sends them one byte per cycle
// while the receiver is ready, most significant first. Depends on vlcbp_pkg and vlcbp_if.
module vlcbp_back #(
    parameter int MAX_CODE_LEN = vlcbp_pkg::MAX_CODE_LEN_DEF,
    localparam int BUF_W = MAX_CODE_LEN + 7,
    localparam int MAX_BYTES = BUF_W / 8,
    localparam int DW = MAX_BYTES * 8,
    localparam int CNT_W = $clog2(MAX_BYTES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  logic [DW-1:0]    i_q_data,
    input  logic [CNT_W-1:0] i_q_nbytes,
    output logic             o_q_pop,
    vlcbp_out_if.source      o_out
);

    logic [DW-1:0]    r_data;
    logic [CNT_W-1:0] r_left;
    logic             take;

    assign take = o_out.valid && o_out.ready;
    assign o_q_pop = i_q_valid && ((r_left == '0) || ((r_left == CNT_W'(1)) && take));

    assign o_out.valid = (r_left != '0);
    assign o_out.out_byte = r_data[DW-1 -: 8];
    assign o_out.last = (r_left == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (o_q_pop) begin
            r_left <= i_q_nbytes;
        end else if (take) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data <= i_q_data;
        end else if (take) begin
            r_data <= r_data << 8;
        end
    end

    a_group_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !o_out.last) |=> o_out.valid)
        else $error("byte group cut short");

endmodule

// ----- hdl/variable_length_code_bit_packer.sv -----
// Variable-length code bit packer, MSB first. The first byte of a request passes the
// queue register, then the output register, before it is offered. Throughput: one
// request per cycle while the byte serializer keeps up; output runs at one byte per
// cycle while the receiver is ready, so a request making n bytes holds the serializer
// while it sends them, and a two-entry queue absorbs the difference. Synchronous
// active-low reset empties the pending bits, the queue and the output register.
module variable_length_code_bit_packer #(
    parameter int MAX_CODE_LEN = vlcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vlcbp_in_if.sink    i_in,
    vlcbp_out_if.source o_out
);

    localparam int BUF_W = MAX_CODE_LEN + 7;
    localparam int MAX_BYTES = BUF_W / 8;
    localparam int DW = MAX_BYTES * 8;
    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    logic             q_full, q_push, q_pop, q_valid;
    logic [DW-1:0]    f_data, q_data;
    logic [CNT_W-1:0] f_nbytes, q_nbytes;

    vlcbp_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (f_data),
        .o_q_nbytes (f_nbytes)
    );

    vlcbp_queue #(.WIDTH(DW + CNT_W), .DEPTH(vlcbp_pkg::QUEUE_DEPTH_DEF)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_data, f_nbytes}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  ({q_data, q_nbytes})
    );

    vlcbp_back #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .i_q_nbytes (q_nbytes),
        .o_q_pop    (q_pop),
        .o_out      (o_out)
    );

endmodule

// ----- verif/variable_length_code_bit_packer_tb.sv -----
// Testbench of the variable-length code bit packer: directed and random requests.
// A built-in predictor checks each byte; the sender has random gaps, the receiver stalls.
// Depends on vlcbp_pkg, the channel interfaces in vlcbp_if.sv and the packer RTL.
module variable_length_code_bit_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = vlcbp_pkg::MAX_CODE_LEN_DEF;
    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_CYCLES = 12;
    localparam int RANDOM_ITEMS = 100;
    localparam int HOLD_OFF_CYCLES = 400;

    localparam int RX_ALWAYS = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_PERIODIC = 2;

    typedef struct packed {
        logic [vlcbp_pkg::BYTE_W-1:0] out_byte;
        logic                         last;
    } t_packed_byte;

    logic i_clk;
    logic i_rst_n;

    vlcbp_in_if  code_if ();
    vlcbp_out_if byte_if ();

    variable_length_code_bit_packer #(
        .MAX_CODE_LEN(MAX_LEN)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (code_if),
        .o_out  (byte_if)
    );

    t_packed_byte expected_bytes[$];
    logic [38:0]  pending_bits;
    int unsigned  pending_count;
    int           fail_count;
    bit           gaps_on;
    int           burst_left;
    int           hold_request;
    int           idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void predict_bytes(input logic [vlcbp_pkg::OP_W-1:0] op,
                                          input logic [vlcbp_pkg::CODE_W-1:0] code,
                                          input logic [vlcbp_pkg::LEN_W-1:0] len_field);
        logic [63:0]  acc;
        int unsigned  len;
        int unsigned  shift;
        int           made;
        t_packed_byte entry;
        made = 0;
        if (op == vlcbp_pkg::OP_FLUSH) begin
            acc = 64'(pending_bits) << (vlcbp_pkg::BYTE_W - pending_count);
            entry.out_byte = acc[vlcbp_pkg::BYTE_W-1:0];
            entry.last = 1'b1;
            expected_bytes.push_back(entry);
            pending_bits = '0;
            pending_count = 0;
            return;
        end
        len = (len_field > MAX_LEN) ? MAX_LEN : len_field;
        if (len == 0) begin
            return;
        end
        acc = (64'(pending_bits) << len) | (64'(code) & ((64'd1 << len) - 64'd1));
        pending_count += len;
        while (pending_count >= vlcbp_pkg::BYTE_W) begin
            shift = pending_count - vlcbp_pkg::BYTE_W;
            entry.out_byte = 8'(acc >> shift);
            entry.last = 1'b0;
            expected_bytes.push_back(entry);
            made++;
            pending_count = shift;
            acc &= (64'd1 << pending_count) - 64'd1;
        end
        if (made > 0) begin
            expected_bytes[expected_bytes.size()-1].last = 1'b1;
        end
        pending_bits = acc[38:0];
    endfunction

    task automatic send_request(input logic [vlcbp_pkg::OP_W-1:0] op,
                                input logic [vlcbp_pkg::CODE_W-1:0] code,
                                input logic [vlcbp_pkg::LEN_W-1:0] len);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            code_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge i_clk);
        code_if.valid = 1'b1;
        code_if.operation = op;
        code_if.code_bits = code;
        code_if.code_length = len;
        do @(posedge i_clk); while (code_if.ready !== 1'b1);
        predict_bytes(op, code, len);
    endtask

    task automatic send_random_request();
        int roll;
        logic [vlcbp_pkg::LEN_W-1:0] len;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            send_request(vlcbp_pkg::OP_FLUSH, $urandom, vlcbp_pkg::LEN_W'($urandom));
            return;
        end
        if (roll < 14) begin
            len = '0;
        end else if (roll < 20) begin
            len = vlcbp_pkg::LEN_W'($urandom_range(33, 63));
        end else if (roll < 35) begin
            len = vlcbp_pkg::LEN_W'($urandom_range(13, 32));
        end else begin
            len = vlcbp_pkg::LEN_W'($urandom_range(1, 12));
        end
        send_request(vlcbp_pkg::OP_APPEND, $urandom, len);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        code_if.valid = 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        gaps_on = 1'b0;
        send_request(vlcbp_pkg::OP_FLUSH, 32'h0, 6'd0);
        send_request(vlcbp_pkg::OP_APPEND, 32'h1, 6'd1);
        send_request(vlcbp_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd0);
        send_request(vlcbp_pkg::OP_APPEND, 32'hFFFF_FF7F, 6'd7);
        send_request(vlcbp_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd32);
        send_request(vlcbp_pkg::OP_APPEND, 32'h0000_0000, 6'd32);
        send_request(vlcbp_pkg::OP_APPEND, 32'h5, 6'd3);
        send_request(vlcbp_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd32);
        send_request(vlcbp_pkg::OP_APPEND, 32'hFFFF_FFFA, 6'd4);
        send_request(vlcbp_pkg::OP_FLUSH, 32'hFFFF_FFFF, 6'd63);
        send_request(vlcbp_pkg::OP_FLUSH, 32'h0, 6'd0);
        send_request(vlcbp_pkg::OP_APPEND, 32'h0000_0000, 6'd40);
        send_request(vlcbp_pkg::OP_APPEND, 32'h1234_5678, 6'd63);
        send_request(vlcbp_pkg::OP_APPEND, 32'h8000_0001, 6'd33);
        send_request(vlcbp_pkg::OP_APPEND, 32'h7F, 6'd7);
        send_request(vlcbp_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd32);
        send_request(vlcbp_pkg::OP_FLUSH, 32'h0, 6'd0);
        send_request(vlcbp_pkg::OP_APPEND, 32'hA5, 6'd8);
        send_request(vlcbp_pkg::OP_APPEND, 32'hDEAD, 6'd16);
        send_request(vlcbp_pkg::OP_APPEND, 32'h2, 6'd2);
        send_request(vlcbp_pkg::OP_FLUSH, 32'h0, 6'd0);
        wait_drained();
    endtask

    task automatic test_random();
        for (int seg = 0; seg < 5; seg++) begin
            gaps_on = (seg == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            burst_left = 0;
            repeat (RANDOM_ITEMS / 5) send_random_request();
        end
        wait_drained();
    endtask

    task automatic test_output_holdoff();
        gaps_on = 1'b0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (24) send_request(vlcbp_pkg::OP_APPEND, $urandom,
                                 vlcbp_pkg::LEN_W'($urandom_range(24, 32)));
        send_request(vlcbp_pkg::OP_FLUSH, $urandom, 6'd0);
        wait_drained();
    endtask

    task automatic test_drain_pause();
        gaps_on = 1'b1;
        burst_left = 0;
        repeat (12) send_random_request();
        wait_drained();
        repeat (12) send_random_request();
        wait_drained();
    endtask

    initial begin
        int phase;
        int mode;
        int hold_left;
        phase = 0;
        mode = RX_ALWAYS;
        hold_left = 0;
        byte_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (phase % 64 == 0) begin
                mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                byte_if.ready = 1'b0;
            end else begin
                case (mode)
                    RX_ALWAYS: begin
                        byte_if.ready = 1'b1;
                    end
                    RX_RANDOM: begin
                        byte_if.ready = ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        byte_if.ready = (phase % 7) < 4;
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_packed_byte want;
        if (i_rst_n && byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
            if (expected_bytes.size() == 0) begin
                note_failure($sformatf("unexpected byte %02h last %0b",
                                       byte_if.out_byte, byte_if.last));
            end else begin
                want = expected_bytes.pop_front();
                if (byte_if.out_byte !== want.out_byte || byte_if.last !== want.last) begin
                    note_failure($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                           want.out_byte, want.last,
                                           byte_if.out_byte, byte_if.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (code_if.valid && code_if.ready) || (byte_if.valid && byte_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("variable_length_code_bit_packer: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        code_if.valid = 1'b0;
        code_if.operation = vlcbp_pkg::OP_APPEND;
        code_if.code_bits = '0;
        code_if.code_length = '0;
        pending_bits = '0;
        pending_count = 0;
        fail_count = 0;
        gaps_on = 1'b0;
        burst_left = 0;
        hold_request = 0;
        idle_cycles = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random();
        test_output_holdoff();
        test_drain_pause();
        if (expected_bytes.size() != 0) begin
            note_failure($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
        end
        if (fail_count == 0) begin
            $display("variable_length_code_bit_packer: match");
        end else begin
            $display("variable_length_code_bit_packer: mismatch");
        end
        $finish;
    end
endmodule
